/* rtl/core/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked assertions shared by the tokenizer RTL. They use the clk and rst_n
// of the module that includes this header.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// The property must hold at every clock edge outside reset.
`define STB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// The expression must never be true outside reset.
`define STB_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define STB_ASSERT(lbl, prop, msg)
`define STB_NEVER(lbl, expr, msg)
`endif
`endif

/* rtl/core/stb_pkg.sv */
// ----------------------------------------------------------------------------
// Source byte tokenizer package
// Token kinds, lexer modes, result word layout and character helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package stb_pkg;

  // Default limit on the text length of one token.
  localparam int MAX_TOKEN_LEN_DEF = 127;

  // Depth of the result queue in front of the output port.
  localparam int FIFO_DEPTH = 4;

  // Characters with a meaning of their own.
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_NL    = 8'h0a;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_SLASH = 8'h2f;
  localparam logic [7:0] CH_COLON = 8'h3a;
  localparam logic [7:0] CH_BSL   = 8'h5c;
  localparam logic [7:0] CH_US    = 8'h5f;

  typedef enum logic [4:0] {
    TK_EOF, TK_INT, TK_STR, TK_PRINT, TK_IDENT, TK_NUMBER, TK_STRING,
    TK_DCOLON, TK_COLON, TK_EQUAL, TK_SEMI, TK_COMMA, TK_LPAREN, TK_RPAREN,
    TK_LBRACK, TK_RBRACK, TK_STAR, TK_HASH, TK_UNKNOWN
  } tok_kind_t;

  typedef enum logic [2:0] {
    LM_IDLE, LM_IDENT, LM_NUMBER, LM_STRING, LM_STRBSL, LM_COLON, LM_SLASH,
    LM_COMMENT
  } lex_mode_t;

  // One result word.
  typedef struct packed {
    tok_kind_t   kind;
    logic [7:0]  text;
    logic        has;
    logic        tok_end;
  } stb_res_t;

  // Up to two result words produced by one source byte, oldest in r0.
  typedef struct packed {
    logic     v0;
    logic     v1;
    stb_res_t r0;
    stb_res_t r1;
  } stb_push_t;

  function automatic stb_res_t mk_res(input tok_kind_t kind, input logic [7:0] text,
                                      input logic has, input logic tok_end);
    stb_res_t r;
    r.kind    = kind;
    r.text    = text;
    r.has     = has;
    r.tok_end = tok_end;
    return r;
  endfunction

  function automatic logic is_alpha(input logic [7:0] b);
    return (b >= 8'h61 && b <= 8'h7a) || (b >= 8'h41 && b <= 8'h5a);
  endfunction

  function automatic logic is_digit(input logic [7:0] b);
    return b >= 8'h30 && b <= 8'h39;
  endfunction

  function automatic logic is_space(input logic [7:0] b);
    return b == 8'h20 || (b >= 8'h09 && b <= 8'h0d);
  endfunction

  // Kind of a byte that stands alone as a token.
  function automatic tok_kind_t symbol_kind(input logic [7:0] b);
    tok_kind_t k;
    case (b)
      8'h3d:   k = TK_EQUAL;
      8'h3b:   k = TK_SEMI;
      8'h2c:   k = TK_COMMA;
      8'h28:   k = TK_LPAREN;
      8'h29:   k = TK_RPAREN;
      8'h5b:   k = TK_LBRACK;
      8'h5d:   k = TK_RBRACK;
      8'h2a:   k = TK_STAR;
      8'h23:   k = TK_HASH;
      default: k = TK_UNKNOWN;
    endcase
    return k;
  endfunction

  // Keyword spelling: keyword 0 is int, 1 is str, 2 is printf.
  function automatic logic [7:0] kw_char(input logic [1:0] k, input logic [2:0] idx);
    logic [47:0] s;
    case (k)
      2'd0:    s = {8'h69, 8'h6e, 8'h74, 24'h0};
      2'd1:    s = {8'h73, 8'h74, 8'h72, 24'h0};
      2'd2:    s = {8'h70, 8'h72, 8'h69, 8'h6e, 8'h74, 8'h66};
      default: s = 48'h0;
    endcase
    case (idx)
      3'd0:    return s[47:40];
      3'd1:    return s[39:32];
      3'd2:    return s[31:24];
      3'd3:    return s[23:16];
      3'd4:    return s[15:8];
      3'd5:    return s[7:0];
      default: return 8'h00;
    endcase
  endfunction

  function automatic logic [2:0] kw_len(input logic [1:0] k);
    case (k)
      2'd0:    return 3'd3;
      2'd1:    return 3'd3;
      2'd2:    return 3'd6;
      default: return 3'd0;
    endcase
  endfunction

  // Drop every keyword that byte b at position idx rules out.
  // Positions of seven and above arrive saturated at seven.
  function automatic logic [2:0] kw_step(input logic [2:0] kw, input logic [2:0] idx,
                                         input logic [7:0] b);
    logic [2:0] r;
    for (int k = 0; k < 3; k++) begin
      r[k] = kw[k] && (idx < kw_len(2'(k))) && (kw_char(2'(k), idx) == b);
    end
    return r;
  endfunction

  // Kind of a finished identifier of saturated length len.
  function automatic tok_kind_t ident_kind(input logic [2:0] kw, input logic [2:0] len);
    if (kw[0] && len == kw_len(2'd0)) return TK_INT;
    if (kw[1] && len == kw_len(2'd1)) return TK_STR;
    if (kw[2] && len == kw_len(2'd2)) return TK_PRINT;
    return TK_IDENT;
  endfunction

endpackage

`default_nettype wire

/* rtl/core/source_byte_tokenizer.sv */
// ----------------------------------------------------------------------------
// Source byte tokenizer
// Streaming lexer: one source byte per word in, token text and kinds out.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake            Word
//   in_       input      in_valid/in_ready    source_byte
//   out_      output     out_valid/out_ready  token_kind, text_byte, has_byte,
//                                             token_end
//
// One source byte is taken per cycle while in_ready is high; the lexer state
// updates in that cycle. A byte yields zero, one or two result words, which
// go into a four-word queue; a two-word byte drains one word at a time.
// in_ready is low while the queue has fewer than two free words, so it
// follows only the queue fill and output stalls.
// Reset is synchronous; there is no clearing pass.
//
`default_nettype none

`include "assert_macros.svh"

module source_byte_tokenizer #(
  parameter int MAX_TOKEN_LEN = stb_pkg::MAX_TOKEN_LEN_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_source_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [4:0] out_token_kind,
  output logic [7:0] out_text_byte,
  output logic       out_has_byte,
  output logic       out_token_end
);

  stb_pkg::stb_push_t push;
  stb_pkg::stb_res_t  out_res;
  logic               step;

  assign step = in_valid && in_ready;

  // Lexer core.
  stb_lexer #(
    .MAX_TOKEN_LEN(MAX_TOKEN_LEN)
  ) u_lexer (
    .clk      (clk),
    .rst_n    (rst_n),
    .step     (step),
    .src_byte (in_source_byte),
    .push     (push)
  );

  // Result queue.
  stb_result_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr_en     (step),
    .push      (push),
    .room      (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res)
  );

  // Output word fields.
  assign out_token_kind = out_res.kind;
  assign out_text_byte  = out_res.text;
  assign out_has_byte   = out_res.has;
  assign out_token_end  = out_res.tok_end;

  // Checks.
  `STB_NEVER(a_slot_order, push.v1 && !push.v0, "second result word without first")
  `STB_ASSERT(a_push_shows, (step && push.v0) |=> out_valid, "written word not shown")
  `STB_ASSERT(a_empty_ready, !out_valid |-> in_ready, "empty queue refuses a byte")

endmodule

`default_nettype wire

/* rtl/core/stb_lexer.sv */
// ----------------------------------------------------------------------------
// Tokenizer lexer core
// Holds the lexer mode, token length and keyword candidates, and turns one
// source byte into up to two result words combinationally.
// ----------------------------------------------------------------------------
`default_nettype none

module stb_lexer #(
  parameter int MAX_TOKEN_LEN = stb_pkg::MAX_TOKEN_LEN_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  logic [7:0]        src_byte,
  output stb_pkg::stb_push_t push
);

  localparam int LW = $clog2(MAX_TOKEN_LEN + 1);
  localparam logic [LW:0] LEN_MAX = (LW + 1)'(MAX_TOKEN_LEN);

  stb_pkg::lex_mode_t mode_r, mode_nxt;
  logic [LW-1:0]      len_r, len_nxt;
  logic [2:0]         kw_r, kw_nxt;

  logic [LW:0] len_p1, len_p2;
  logic        full1, full2, len_full;
  logic [2:0]  len_sat;
  logic [2:0]  kw_cont, kw_start;
  logic        b_nul, b_nl, b_space, b_digit, b_idst, b_idch;
  logic        b_quote, b_bsl, b_colon, b_slash;
  logic        go_idle;

  stb_pkg::stb_res_t ra, rb, ri;
  logic              ra_v, rb_v, ri_v;

  // Length arithmetic, one bit wider so the limit compare never wraps.
  assign len_p1   = {1'b0, len_r} + (LW + 1)'(1);
  assign len_p2   = {1'b0, len_r} + (LW + 1)'(2);
  assign full1    = len_p1 >= LEN_MAX;
  assign full2    = len_p2 >= LEN_MAX;
  assign len_full = {1'b0, len_r} >= LEN_MAX;
  assign len_sat  = (len_r >= LW'(7)) ? 3'd7 : len_r[2:0];

  // Keyword candidates after this byte, inside and at the start of a word.
  assign kw_cont  = stb_pkg::kw_step(kw_r, len_sat, src_byte);
  assign kw_start = stb_pkg::kw_step(3'b111, 3'd0, src_byte);

  // Character classes.
  assign b_nul   = src_byte == stb_pkg::CH_NUL;
  assign b_nl    = src_byte == stb_pkg::CH_NL;
  assign b_space = stb_pkg::is_space(src_byte);
  assign b_digit = stb_pkg::is_digit(src_byte);
  assign b_idst  = stb_pkg::is_alpha(src_byte) || src_byte == stb_pkg::CH_US;
  assign b_idch  = b_idst || b_digit;
  assign b_quote = src_byte == stb_pkg::CH_QUOTE;
  assign b_bsl   = src_byte == stb_pkg::CH_BSL;
  assign b_colon = src_byte == stb_pkg::CH_COLON;
  assign b_slash = src_byte == stb_pkg::CH_SLASH;

  // Decide whether this byte is lexed afresh from the idle mode.
  always_comb begin
    case (mode_r)
      stb_pkg::LM_IDENT:   go_idle = !b_idch;
      stb_pkg::LM_NUMBER:  go_idle = !b_digit;
      stb_pkg::LM_STRING:  go_idle = len_full ? !b_quote : b_nul;
      stb_pkg::LM_STRBSL:  go_idle = !b_quote && (b_nul || full1);
      stb_pkg::LM_COLON:   go_idle = !b_colon;
      stb_pkg::LM_SLASH:   go_idle = !b_slash;
      stb_pkg::LM_COMMENT: go_idle = b_nl || b_nul;
      default:             go_idle = 1'b1;
    endcase
  end

  // Next state.
  always_comb begin
    mode_nxt = mode_r;
    len_nxt  = len_r;
    kw_nxt   = kw_r;
    case (mode_r)
      stb_pkg::LM_IDENT: begin
        if (b_idch) begin
          kw_nxt = kw_cont;
          if (full1) begin
            mode_nxt = stb_pkg::LM_IDLE;
            len_nxt  = '0;
          end else begin
            len_nxt = len_p1[LW-1:0];
          end
        end
      end
      stb_pkg::LM_NUMBER: begin
        if (b_digit) begin
          if (full1) begin
            mode_nxt = stb_pkg::LM_IDLE;
            len_nxt  = '0;
          end else begin
            len_nxt = len_p1[LW-1:0];
          end
        end
      end
      stb_pkg::LM_STRING: begin
        // A long string stays here at the limit so a closing quote is eaten.
        if (len_full || b_quote) begin
          mode_nxt = stb_pkg::LM_IDLE;
          len_nxt  = '0;
        end else if (b_bsl) begin
          mode_nxt = stb_pkg::LM_STRBSL;
        end else if (!b_nul) begin
          len_nxt = len_p1[LW-1:0];
        end
      end
      stb_pkg::LM_STRBSL: begin
        if (b_quote) begin
          mode_nxt = stb_pkg::LM_STRING;
          len_nxt  = len_p1[LW-1:0];
        end else if (full1) begin
          // Backslash text filled the token; this byte is lexed afresh.
          mode_nxt = stb_pkg::LM_IDLE;
          len_nxt  = '0;
        end else if (!b_nul) begin
          if (b_bsl) begin
            mode_nxt = stb_pkg::LM_STRBSL;
            len_nxt  = len_p1[LW-1:0];
          end else begin
            mode_nxt = stb_pkg::LM_STRING;
            len_nxt  = len_p2[LW-1:0];
          end
        end
      end
      stb_pkg::LM_COLON: begin
        if (b_colon) mode_nxt = stb_pkg::LM_IDLE;
      end
      stb_pkg::LM_SLASH: begin
        if (b_slash) mode_nxt = stb_pkg::LM_COMMENT;
      end
      default: begin
      end
    endcase

    // Start of a new token from the idle mode.
    if (go_idle) begin
      mode_nxt = stb_pkg::LM_IDLE;
      len_nxt  = '0;
      if (b_idst) begin
        mode_nxt = stb_pkg::LM_IDENT;
        kw_nxt   = kw_start;
        len_nxt  = LW'(1);
      end else if (b_digit) begin
        mode_nxt = stb_pkg::LM_NUMBER;
        len_nxt  = LW'(1);
      end else if (b_quote) begin
        mode_nxt = stb_pkg::LM_STRING;
      end else if (b_colon) begin
        mode_nxt = stb_pkg::LM_COLON;
      end else if (b_slash) begin
        mode_nxt = stb_pkg::LM_SLASH;
      end
    end
  end

  // Result words. The kind reads as zero until the last word of a token.
  always_comb begin
    ra   = stb_pkg::mk_res(stb_pkg::TK_EOF, 8'h00, 1'b0, 1'b0);
    rb   = ra;
    ri   = ra;
    ra_v = 1'b0;
    rb_v = 1'b0;
    ri_v = 1'b0;
    case (mode_r)
      stb_pkg::LM_IDENT: begin
        ra_v = 1'b1;
        if (b_idch) begin
          // At the limit the length is past every keyword.
          ra = full1 ? stb_pkg::mk_res(stb_pkg::TK_IDENT, src_byte, 1'b1, 1'b1)
                     : stb_pkg::mk_res(stb_pkg::TK_EOF, src_byte, 1'b1, 1'b0);
        end else begin
          ra = stb_pkg::mk_res(stb_pkg::ident_kind(kw_r, len_sat), 8'h00, 1'b0, 1'b1);
        end
      end
      stb_pkg::LM_NUMBER: begin
        ra_v = 1'b1;
        if (b_digit) begin
          ra = full1 ? stb_pkg::mk_res(stb_pkg::TK_NUMBER, src_byte, 1'b1, 1'b1)
                     : stb_pkg::mk_res(stb_pkg::TK_EOF, src_byte, 1'b1, 1'b0);
        end else begin
          ra = stb_pkg::mk_res(stb_pkg::TK_NUMBER, 8'h00, 1'b0, 1'b1);
        end
      end
      stb_pkg::LM_STRING: begin
        if (!len_full) begin
          if (b_quote || b_nul) begin
            ra_v = 1'b1;
            ra   = stb_pkg::mk_res(stb_pkg::TK_STRING, 8'h00, 1'b0, 1'b1);
          end else if (!b_bsl) begin
            ra_v = 1'b1;
            ra   = full1 ? stb_pkg::mk_res(stb_pkg::TK_STRING, src_byte, 1'b1, 1'b1)
                         : stb_pkg::mk_res(stb_pkg::TK_EOF, src_byte, 1'b1, 1'b0);
          end
        end
      end
      stb_pkg::LM_STRBSL: begin
        ra_v = 1'b1;
        if (b_quote) begin
          // Escaped quote becomes plain text.
          ra = full1 ? stb_pkg::mk_res(stb_pkg::TK_STRING, stb_pkg::CH_QUOTE, 1'b1, 1'b1)
                     : stb_pkg::mk_res(stb_pkg::TK_EOF, stb_pkg::CH_QUOTE, 1'b1, 1'b0);
        end else if (b_nul || full1) begin
          // The held backslash closes the string.
          ra = stb_pkg::mk_res(stb_pkg::TK_STRING, stb_pkg::CH_BSL, 1'b1, 1'b1);
        end else begin
          ra = stb_pkg::mk_res(stb_pkg::TK_EOF, stb_pkg::CH_BSL, 1'b1, 1'b0);
          if (!b_bsl) begin
            rb_v = 1'b1;
            rb   = full2 ? stb_pkg::mk_res(stb_pkg::TK_STRING, src_byte, 1'b1, 1'b1)
                         : stb_pkg::mk_res(stb_pkg::TK_EOF, src_byte, 1'b1, 1'b0);
          end
        end
      end
      stb_pkg::LM_COLON: begin
        ra_v = 1'b1;
        if (b_colon) begin
          rb_v = 1'b1;
          ra   = stb_pkg::mk_res(stb_pkg::TK_EOF, stb_pkg::CH_COLON, 1'b1, 1'b0);
          rb   = stb_pkg::mk_res(stb_pkg::TK_DCOLON, stb_pkg::CH_COLON, 1'b1, 1'b1);
        end else begin
          ra = stb_pkg::mk_res(stb_pkg::TK_COLON, stb_pkg::CH_COLON, 1'b1, 1'b1);
        end
      end
      stb_pkg::LM_SLASH: begin
        if (!b_slash) begin
          ra_v = 1'b1;
          ra   = stb_pkg::mk_res(stb_pkg::TK_UNKNOWN, stb_pkg::CH_SLASH, 1'b1, 1'b1);
        end
      end
      default: begin
      end
    endcase

    // Word from lexing the byte afresh.
    if (go_idle) begin
      if (b_nul) begin
        ri_v = 1'b1;
        ri   = stb_pkg::mk_res(stb_pkg::TK_EOF, 8'h00, 1'b0, 1'b1);
      end else if (b_idst || b_digit) begin
        ri_v = 1'b1;
        ri   = stb_pkg::mk_res(stb_pkg::TK_EOF, src_byte, 1'b1, 1'b0);
      end else if (!(b_space || b_quote || b_colon || b_slash)) begin
        ri_v = 1'b1;
        ri   = stb_pkg::mk_res(stb_pkg::symbol_kind(src_byte), src_byte, 1'b1, 1'b1);
      end
    end
  end

  // Pack the words in order; the second slot is only used after the first.
  always_comb begin
    push.v0 = ra_v || ri_v;
    push.v1 = ra_v && (rb_v || ri_v);
    push.r0 = ra_v ? ra : ri;
    push.r1 = rb_v ? rb : ri;
  end

  // State registers advance on every accepted byte.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= stb_pkg::LM_IDLE;
      len_r  <= '0;
      kw_r   <= 3'b111;
    end else if (step) begin
      mode_r <= mode_nxt;
      len_r  <= len_nxt;
      kw_r   <= kw_nxt;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/stb_result_fifo.sv */
// ----------------------------------------------------------------------------
// Tokenizer result queue
// Small queue that takes up to two result words per cycle and hands one word
// per cycle to the output port while out_ready is high.
// ----------------------------------------------------------------------------
`default_nettype none

module stb_result_fifo (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               wr_en,
  input  stb_pkg::stb_push_t push,
  output logic               room,
  output logic               out_valid,
  input  logic               out_ready,
  output stb_pkg::stb_res_t  out_res
);

  localparam int PW = $clog2(stb_pkg::FIFO_DEPTH);
  localparam int CW = $clog2(stb_pkg::FIFO_DEPTH + 1);

  stb_pkg::stb_res_t mem [stb_pkg::FIFO_DEPTH];
  logic [PW-1:0]     wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  logic [1:0]        n_wr;
  logic              pop;

  // Number of words written and read this cycle.
  assign n_wr = wr_en ? ({1'b0, push.v0} + {1'b0, push.v1}) : 2'd0;
  assign pop  = out_valid && out_ready;

  // Pointer and fill updates.
  assign wr_ptr_nxt = wr_ptr_r + PW'(n_wr);
  assign rd_ptr_nxt = rd_ptr_r + PW'(pop);
  assign count_nxt  = count_r + CW'(n_wr) - CW'(pop);

  // Room for the two words a byte may produce.
  assign room      = count_r <= CW'(stb_pkg::FIFO_DEPTH - 2);
  assign out_valid = count_r != '0;
  assign out_res   = mem[rd_ptr_r];

  // Word storage.
  always_ff @(posedge clk) begin
    if (wr_en && push.v0) mem[wr_ptr_r] <= push.r0;
    if (wr_en && push.v1) mem[wr_ptr_r + PW'(1)] <= push.r1;
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

`default_nettype wire
